### sv/static_linked_list_engine_assert.svh
// Assertion macros for the static linked list engine checker.
// Depends on nothing; included by the files that assert.
`ifndef STATIC_LINKED_LIST_ENGINE_ASSERT_SVH
`define STATIC_LINKED_LIST_ENGINE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SLL_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SLL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

### sv/sll_pkg.sv
// Shared types for the static linked list engine: port words, request and
// status codes, controller states and the controller/datapath command set.
// Depends on nothing.
package sll_pkg;

  localparam int POS_W  = 7;
  localparam int SLOT_W = 6;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_SEARCH = 2'd2,
    REQ_SUBST  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_NOTFOUND = 2'd1,
    STS_FULL     = 2'd2,
    STS_BADPOS   = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic signed [31:0] key_value;
    logic signed [31:0] new_value;
    logic [POS_W-1:0]  position;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE,
    ST_I_RD, ST_I_CHK, ST_I_FREE, ST_I_NN, ST_I_AT, ST_I_W0, ST_I_W1, ST_I_W2,
    ST_W_HEAD, ST_W_CHK, ST_W_CMP,
    ST_D_W0, ST_D_W1, ST_D_W2
  } state_t;

  // link memory read address
  typedef enum logic [2:0] {
    RD_NONE, RD_HEAD, RD_AT, RD_CUR, RD_FREE, RD_Q
  } rd_sel_t;

  // register updates from the link read data
  typedef enum logic [2:0] {
    U_NONE, U_AT, U_NN, U_TMP, U_CUR, U_ADV
  } upd_t;

  // link memory write: address and data
  typedef enum logic [2:0] {
    W_NONE, W_CLR, W_FREE_TMP, W_NN_TMP, W_AT_NN, W_PREV_TMP, W_CUR_Q, W_FREE_CUR
  } wr_sel_t;

  typedef enum logic [1:0] {
    V_NONE, V_NN, V_CUR
  } vwr_t;

  typedef enum logic [1:0] {
    SLOT_ZERO, SLOT_NN, SLOT_CUR
  } slot_sel_t;

  typedef struct packed {
    logic      ld_in;
    rd_sel_t   rd_sel;
    upd_t      upd;
    wr_sel_t   wr_sel;
    vwr_t      vwr;
    logic      done;
    status_t   status;
    slot_sel_t slot_sel;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic q_zero;
    logic ins_more;
    logic ins_over;
    logic walk_end;
    logic key_hit;
    req_t req;
  } sts_t;

endpackage

### sv/sll_ctrl.sv
// Controller for the static linked list engine: sequences the clearing
// pass, list walks and pointer rewrites. Depends on sll_pkg.
module sll_ctrl import sll_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  in_word_t in_word,
  input  sts_t     sts,
  output cmd_t     cmd,
  output logic     busy
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.wr_sel = W_CLR;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.ld_in = 1'b1;
          if (req_t'(in_word.req_type) == REQ_INSERT) begin
            if (in_word.position == '0) begin
              cmd.done   = 1'b1;
              cmd.status = STS_BADPOS;
            end else if (in_word.position == POS_W'(1)) begin
              state_nxt = ST_I_FREE;
            end else begin
              state_nxt = ST_I_RD;
            end
          end else begin
            cmd.rd_sel = RD_HEAD;
            state_nxt  = ST_W_HEAD;
          end
        end
      end
      ST_I_RD: begin
        cmd.rd_sel = RD_AT;
        state_nxt  = ST_I_CHK;
      end
      ST_I_CHK: begin
        if (sts.q_zero || sts.ins_over) begin
          cmd.done   = 1'b1;
          cmd.status = STS_BADPOS;
          state_nxt  = ST_IDLE;
        end else begin
          cmd.upd   = U_AT;
          state_nxt = sts.ins_more ? ST_I_RD : ST_I_FREE;
        end
      end
      ST_I_FREE: begin
        cmd.rd_sel = RD_FREE;
        state_nxt  = ST_I_NN;
      end
      ST_I_NN: begin
        if (sts.q_zero) begin
          cmd.done   = 1'b1;
          cmd.status = STS_FULL;
          state_nxt  = ST_IDLE;
        end else begin
          // take the free head and fetch its successor
          cmd.upd    = U_NN;
          cmd.rd_sel = RD_Q;
          state_nxt  = ST_I_AT;
        end
      end
      ST_I_AT: begin
        cmd.upd    = U_TMP;
        cmd.rd_sel = RD_AT;
        state_nxt  = ST_I_W0;
      end
      ST_I_W0: begin
        cmd.wr_sel = W_FREE_TMP;
        cmd.upd    = U_TMP;
        cmd.vwr    = V_NN;
        state_nxt  = ST_I_W1;
      end
      ST_I_W1: begin
        cmd.wr_sel = W_NN_TMP;
        state_nxt  = ST_I_W2;
      end
      ST_I_W2: begin
        cmd.wr_sel   = W_AT_NN;
        cmd.done     = 1'b1;
        cmd.status   = STS_OK;
        cmd.slot_sel = SLOT_NN;
        state_nxt    = ST_IDLE;
      end
      ST_W_HEAD: begin
        cmd.upd   = U_CUR;
        state_nxt = ST_W_CHK;
      end
      ST_W_CHK: begin
        if (sts.walk_end) begin
          cmd.done   = 1'b1;
          cmd.status = STS_NOTFOUND;
          state_nxt  = ST_IDLE;
        end else begin
          cmd.rd_sel = RD_CUR;
          state_nxt  = ST_W_CMP;
        end
      end
      ST_W_CMP: begin
        if (sts.key_hit) begin
          unique case (sts.req)
            REQ_SEARCH: begin
              cmd.done     = 1'b1;
              cmd.status   = STS_OK;
              cmd.slot_sel = SLOT_CUR;
              state_nxt    = ST_IDLE;
            end
            REQ_SUBST: begin
              cmd.vwr      = V_CUR;
              cmd.done     = 1'b1;
              cmd.status   = STS_OK;
              cmd.slot_sel = SLOT_CUR;
              state_nxt    = ST_IDLE;
            end
            REQ_DELETE: begin
              cmd.upd   = U_TMP;
              state_nxt = ST_D_W0;
            end
            REQ_INSERT: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end else begin
          cmd.upd   = U_ADV;
          state_nxt = ST_W_CHK;
        end
      end
      ST_D_W0: begin
        // unlink the hit node and fetch the free head
        cmd.wr_sel = W_PREV_TMP;
        cmd.rd_sel = RD_FREE;
        state_nxt  = ST_D_W1;
      end
      ST_D_W1: begin
        cmd.wr_sel = W_CUR_Q;
        state_nxt  = ST_D_W2;
      end
      ST_D_W2: begin
        cmd.wr_sel   = W_FREE_CUR;
        cmd.done     = 1'b1;
        cmd.status   = STS_OK;
        cmd.slot_sel = SLOT_CUR;
        state_nxt    = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

### sv/sll_dpath.sv
// Datapath for the static linked list engine: link and value memories,
// walk pointers, step counter and the result register. Depends on sll_pkg.
module sll_dpath import sll_pkg::*; #(
  parameter int NODES = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_word_t  in_word,
  input  cmd_t      cmd,
  output sts_t      sts,
  output logic      out_valid,
  output out_word_t out_word
);

  localparam int LW = $clog2(NODES);
  localparam int CW = (LW + 1 > POS_W) ? LW + 1 : POS_W;

  logic [LW-1:0] link_mem [NODES];
  logic [31:0]   val_mem  [NODES];

  in_word_t      req_r;
  logic [LW-1:0] at_r, nn_r, cur_r, prev_r, tmp_r, link_q_r, clr_r;
  logic [CW-1:0] cnt_r;
  logic [31:0]   val_q_r;
  logic          out_valid_r;
  out_word_t     out_word_r;

  logic [LW-1:0] rd_addr, wr_addr, wr_data, clr_val, vwr_addr, slot_src;
  logic          wr_en;
  logic [CW:0]   cnt_inc, pos_ext;
  logic [LW+SLOT_W-1:0] slot_ext;

  // reset image of the link store: free chain 0 -> 2 -> ... -> last, head empty
  always_comb begin
    if (clr_r == '0) begin
      clr_val = LW'(2);
    end else if (clr_r == LW'(1) || clr_r == LW'(NODES - 1)) begin
      clr_val = '0;
    end else begin
      clr_val = clr_r + LW'(1);
    end
  end

  always_comb begin
    unique case (cmd.rd_sel)
      RD_NONE: rd_addr = '0;
      RD_HEAD: rd_addr = LW'(1);
      RD_AT:   rd_addr = at_r;
      RD_CUR:  rd_addr = cur_r;
      RD_FREE: rd_addr = '0;
      RD_Q:    rd_addr = link_q_r;
      default: rd_addr = '0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = '0;
    wr_data = '0;
    unique case (cmd.wr_sel)
      W_NONE:     wr_en = 1'b0;
      W_CLR:      begin wr_addr = clr_r;  wr_data = clr_val;  end
      W_FREE_TMP: begin wr_addr = '0;     wr_data = tmp_r;    end
      W_NN_TMP:   begin wr_addr = nn_r;   wr_data = tmp_r;    end
      W_AT_NN:    begin wr_addr = at_r;   wr_data = nn_r;     end
      W_PREV_TMP: begin wr_addr = prev_r; wr_data = tmp_r;    end
      W_CUR_Q:    begin wr_addr = cur_r;  wr_data = link_q_r; end
      W_FREE_CUR: begin wr_addr = '0;     wr_data = cur_r;    end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      link_mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_sel != RD_NONE) begin
      link_q_r <= link_mem[rd_addr];
    end
  end

  assign vwr_addr = (cmd.vwr == V_NN) ? nn_r : cur_r;

  always_ff @(posedge clk) begin
    if (cmd.vwr != V_NONE) begin
      val_mem[vwr_addr] <= req_r.new_value;
    end
    val_q_r <= val_mem[cur_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      req_r  <= in_word;
      at_r   <= LW'(1);
      prev_r <= LW'(1);
      cnt_r  <= (req_t'(in_word.req_type) == REQ_INSERT) ? CW'(1) : '0;
    end
    unique case (cmd.upd)
      U_NONE: ;
      U_AT: begin
        at_r  <= link_q_r;
        cnt_r <= cnt_r + CW'(1);
      end
      U_NN:  nn_r  <= link_q_r;
      U_TMP: tmp_r <= link_q_r;
      U_CUR: cur_r <= link_q_r;
      U_ADV: begin
        prev_r <= cur_r;
        cur_r  <= link_q_r;
        cnt_r  <= cnt_r + CW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.done;
      if (cmd.wr_sel == W_CLR) begin
        clr_r <= clr_r + LW'(1);
      end
    end
  end

  always_comb begin
    unique case (cmd.slot_sel)
      SLOT_NN:  slot_src = nn_r;
      SLOT_CUR: slot_src = cur_r;
      default:  slot_src = '0;
    endcase
  end

  assign slot_ext = {{SLOT_W{1'b0}}, slot_src};

  always_ff @(posedge clk) begin
    if (cmd.done) begin
      out_word_r.status <= cmd.status;
      out_word_r.slot   <= slot_ext[SLOT_W-1:0];
    end
  end

  assign cnt_inc = {1'b0, cnt_r} + (CW + 1)'(1);
  assign pos_ext = (CW + 1)'(req_r.position);

  always_comb begin
    sts.clr_last = (clr_r == LW'(NODES - 1));
    sts.q_zero   = (link_q_r == '0);
    sts.ins_more = (cnt_inc < pos_ext);
    sts.ins_over = (cnt_r > CW'(NODES));
    sts.walk_end = (cur_r == '0) || (cnt_r >= CW'(NODES));
    sts.key_hit  = (val_q_r == $unsigned(req_r.key_value));
    sts.req      = req_t'(req_r.req_type);
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

### sv/static_linked_list_engine.sv
// Channel   | Ports                     | Handshake
// ----------+---------------------------+----------------------------------------
// request   | start, busy, in_word      | word taken when start && !busy
// result    | out_valid, out_word       | one-cycle strobe, cannot be held off
//
// Reset clears the FSM, then a clearing pass rebuilds the link store with
// busy high. Link reads are registered, so each list step takes a read
// state and a check state. An insert walks to its position before it takes
// a free node; search, substitute and delete walk from the head, and a
// 64-node store holds 62 data nodes. busy falls in the cycle the result
// strobes; the receiver never stalls.
// Top level of the static linked list engine; depends on sll_pkg, sll_ctrl
// and sll_dpath.
module static_linked_list_engine import sll_pkg::*; #(
  parameter int NODES = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  in_word_t  in_word,
  output logic      busy,
  output logic      out_valid,
  output out_word_t out_word
);

  cmd_t cmd;
  sts_t sts;

  sll_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_word (in_word),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  sll_dpath #(.NODES(NODES)) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

### sv/sll_checker.sv
// Port-level checks for the static linked list engine, bound to the top.
// Depends on sll_pkg and static_linked_list_engine_assert.svh.
`include "static_linked_list_engine_assert.svh"

module sll_checker import sll_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_word_t  in_word,
  input logic      out_valid,
  input out_word_t out_word
);

  logic take_w, fail_w, pos0_w, key_req_w;

  assign take_w    = start && !busy;
  assign fail_w    = out_valid && (out_word.status != STS_OK);
  assign pos0_w    = take_w && (in_word.req_type == REQ_INSERT) && (in_word.position == '0);
  assign key_req_w = take_w && (in_word.req_type != REQ_INSERT);

  // a failed request never names a node
  `SLL_ASSERT_SAME(a_slot_zero, clk, rst_n, fail_w, out_word.slot == '0)

  // the result strobe comes only as the engine goes idle
  `SLL_ASSERT_SAME(a_idle_on_word, clk, rst_n, out_valid, !busy)

  // insert at position zero is refused at once
  `SLL_ASSERT_NEXT(a_pos_zero, clk, rst_n, pos0_w, out_valid && (out_word.status == STS_BADPOS))

  // key requests always walk at least the head link first
  `SLL_ASSERT_NEXT(a_walk_latency, clk, rst_n, key_req_w, !out_valid && busy)

endmodule

bind static_linked_list_engine sll_checker u_sll_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_word  (out_word)
);
